// ----- rtl/mmtb_pkg.sv -----
package mmtb_pkg;

  localparam int ROWS_W   = 11;
  localparam int INNER_W  = 12;
  localparam int COLS_W   = 11;
  localparam int CFG_W    = 12;
  localparam int POS_W    = 11;
  localparam int BPOS_W   = 10;
  localparam int APOS_W   = 10;
  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 44;
  localparam int DOT_W    = 43;
  localparam int INDEX_W  = 20;
  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;
  localparam int MAX_INNER = 2048;

  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } reg_index_t;

  // One classified word on its way from the front end to the datapath.
  typedef struct packed {
    logic                 load;      // A row element: store it
    logic                 row_done;  // last element of its row
    logic                 last;      // final result of the job
    logic [INDEX_W-1:0]   index;
    logic [ELEM_W-1:0]    value;
  } op_t;

endpackage

// ----- rtl/matrix_multiply_transposed_b.sv -----
// Streaming integer matrix multiply, B supplied transposed.
// Input channel (in_valid/in_ready, element_value): one 16-bit word per
// element, first a row of A (inner_dim words, stored), then cols_b rows of
// B transposed. Each B row is multiplied word by word with the stored A row.
// Output channel (out_valid/out_ready): one word per B row with out_index,
// the 43-bit dot_value and last_of_job on the final result of the product.
// Configuration: cfg_write with cfg_index/cfg_data, taken at once; write only
// while idle. Zero counts as one, oversize values saturate.
// Throughput: one element per cycle while the receiver takes results, set by
// the single multiply-accumulate in the datapath. Once the last element of a
// B row is accepted, its result passes through the queue, the row store read
// and the multiply, then is accumulated into the output register.
// A four-deep queue decouples the counting front end from the datapath.
// When the receiver stalls, the datapath holds, the queue fills and in_ready
// drops; no word is lost. Reset clears counters, queue and accumulator and
// sets all registers to 1; the A row store is not cleared.
module matrix_multiply_transposed_b #(
  parameter int ROW_DEPTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [mmtb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mmtb_pkg::ELEM_W-1:0]    element_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mmtb_pkg::INDEX_W-1:0]   out_index,
  output logic [mmtb_pkg::DOT_W-1:0]     dot_value,
  output logic                           last_of_job
);
  import mmtb_pkg::*;

  localparam int ADDR_W = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

  logic [ROWS_W-1:0]  rows_a;
  logic [INNER_W-1:0] inner_dim;
  logic [COLS_W-1:0]  cols_b;

  logic               accept;
  logic               q_full;
  logic               q_avail;
  logic               q_pop;
  op_t                f_op;
  logic [ADDR_W-1:0]  f_slot;
  op_t                q_op;
  logic [ADDR_W-1:0]  q_slot;

  // Register file: decode the index, ignore unused codes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= ROWS_W'(1);
      inner_dim <= INNER_W'(1);
      cols_b    <= COLS_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data[ROWS_W-1:0];
        REG_INNER_DIM: inner_dim <= cfg_data[INNER_W-1:0];
        REG_COLS_B:    cols_b    <= cfg_data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  mmtb_front #(
    .ROW_DEPTH (ROW_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .rows_a        (rows_a),
    .inner_dim     (inner_dim),
    .cols_b        (cols_b),
    .accept        (accept),
    .element_value (element_value),
    .op            (f_op),
    .slot          (f_slot)
  );

  mmtb_queue #(
    .ADDR_W (ADDR_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_op   (f_op),
    .push_slot (f_slot),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head_op   (q_op),
    .head_slot (q_slot)
  );

  mmtb_back #(
    .ROW_DEPTH (ROW_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .avail       (q_avail),
    .head_op     (q_op),
    .head_slot   (q_slot),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_index   (out_index),
    .dot_value   (dot_value),
    .last_of_job (last_of_job)
  );

  // A word just taken is waiting in the queue on the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    accept |=> q_avail)
    else $error("accepted word missing from queue");

  // An empty queue never refuses input.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !q_avail |-> in_ready)
    else $error("input refused with empty queue");

  // Nothing is popped that is not there.
  a_pop_avail: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_avail)
    else $error("pop from empty queue");

endmodule

// ----- rtl/mmtb_front.sv -----
module mmtb_front #(
  parameter int ROW_DEPTH = 2048,
  parameter int ADDR_W    = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [mmtb_pkg::ROWS_W-1:0]    rows_a,
  input  logic [mmtb_pkg::INNER_W-1:0]   inner_dim,
  input  logic [mmtb_pkg::COLS_W-1:0]    cols_b,
  input  logic                           accept,
  input  logic [mmtb_pkg::ELEM_W-1:0]    element_value,
  output mmtb_pkg::op_t                  op,
  output logic [ADDR_W-1:0]              slot
);
  import mmtb_pkg::*;

  localparam int INNER_CAP_I = (ROW_DEPTH < MAX_INNER) ? ROW_DEPTH : MAX_INNER;
  localparam logic [INNER_W-1:0] INNER_CAP = INNER_W'(INNER_CAP_I);
  localparam logic [ROWS_W-1:0]  ROWS_CAP  = ROWS_W'(MAX_ROWS);
  localparam logic [COLS_W-1:0]  COLS_CAP  = COLS_W'(MAX_COLS);

  logic [POS_W-1:0]   element_pos;
  logic               loading_a_row;
  logic [BPOS_W-1:0]  b_row_pos;
  logic [APOS_W-1:0]  a_row_pos;
  logic [INDEX_W-1:0] output_pos;

  logic [ROWS_W-1:0]  rows_e;
  logic [COLS_W-1:0]  cols_e;
  logic [INNER_W-1:0] inner_e;
  logic [INNER_W-1:0] pos_inc;
  logic [COLS_W-1:0]  b_inc;
  logic [ROWS_W-1:0]  a_inc;
  logic               row_done;
  logic               last_col;
  logic               last_row;

  // Zero counts as one, oversize saturates.
  always_comb begin
    rows_e  = (rows_a == '0) ? ROWS_W'(1) : ((rows_a > ROWS_CAP) ? ROWS_CAP : rows_a);
    cols_e  = (cols_b == '0) ? COLS_W'(1) : ((cols_b > COLS_CAP) ? COLS_CAP : cols_b);
    inner_e = (inner_dim == '0) ? INNER_W'(1)
            : ((inner_dim > INNER_CAP) ? INNER_CAP : inner_dim);
    pos_inc  = {1'b0, element_pos} + INNER_W'(1);
    b_inc    = {1'b0, b_row_pos} + COLS_W'(1);
    a_inc    = {1'b0, a_row_pos} + ROWS_W'(1);
    row_done = (pos_inc >= inner_e);
    last_col = (b_inc >= cols_e);
    last_row = (a_inc >= rows_e);
  end

  always_comb begin
    op.load     = loading_a_row;
    op.row_done = row_done;
    op.last     = last_col && last_row;
    op.index    = output_pos;
    op.value    = element_value;
    slot        = ADDR_W'(element_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_pos   <= '0;
      loading_a_row <= 1'b1;
      b_row_pos     <= '0;
      a_row_pos     <= '0;
      output_pos    <= '0;
    end else if (accept) begin
      if (!row_done) begin
        element_pos <= pos_inc[POS_W-1:0];
      end else if (loading_a_row) begin
        element_pos   <= '0;
        loading_a_row <= 1'b0;
      end else begin
        element_pos <= '0;
        output_pos  <= output_pos + INDEX_W'(1);
        if (last_col) begin
          b_row_pos     <= '0;
          loading_a_row <= 1'b1;
          if (last_row) begin
            a_row_pos  <= '0;
            output_pos <= '0;
          end else begin
            a_row_pos <= a_inc[APOS_W-1:0];
          end
        end else begin
          b_row_pos <= b_inc[BPOS_W-1:0];
        end
      end
    end
  end

endmodule

// ----- rtl/mmtb_queue.sv -----
module mmtb_queue #(
  parameter int ADDR_W = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mmtb_pkg::op_t      push_op,
  input  logic [ADDR_W-1:0]  push_slot,
  output logic               full,
  input  logic               pop,
  output logic               avail,
  output mmtb_pkg::op_t      head_op,
  output logic [ADDR_W-1:0]  head_slot
);
  import mmtb_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  op_t               ops   [DEPTH];
  logic [ADDR_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  assign full      = (count == (PTR_W+1)'(DEPTH));
  assign avail     = (count != '0);
  assign head_op   = ops[rd_ptr];
  assign head_slot = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ops[wr_ptr]   <= push_op;
      slots[wr_ptr] <= push_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/mmtb_back.sv -----
module mmtb_back #(
  parameter int ROW_DEPTH = 2048,
  parameter int ADDR_W    = 11
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            avail,
  input  mmtb_pkg::op_t                   head_op,
  input  logic [ADDR_W-1:0]               head_slot,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mmtb_pkg::INDEX_W-1:0]    out_index,
  output logic [mmtb_pkg::DOT_W-1:0]      dot_value,
  output logic                            last_of_job
);
  import mmtb_pkg::*;

  logic [ELEM_W-1:0] a_row_store [ROW_DEPTH];
  logic [ELEM_W-1:0] rd_data;

  logic              advance;
  logic              s1_valid;
  op_t               s1_op;
  logic              s2_valid;
  op_t               s2_op;
  logic [PROD_W-1:0] product;
  logic [ACC_W-1:0]  accumulator;
  logic [ACC_W-1:0]  sum;
  logic              mac;

  // The whole datapath moves in lockstep; it holds only while a result waits.
  assign advance = !out_valid || out_ready;
  assign pop     = advance && avail;
  assign mac     = s2_valid && !s2_op.load;
  assign sum     = accumulator + ACC_W'(product);

  always_ff @(posedge clk) begin
    if (pop && head_op.load) begin
      a_row_store[head_slot] <= head_op.value;
    end
    if (pop) begin
      rd_data <= a_row_store[head_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op   <= head_op;
      s2_op   <= s1_op;
      product <= PROD_W'(rd_data) * PROD_W'(s1_op.value);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && mac && s2_op.row_done) begin
      out_index   <= s2_op.index;
      dot_value   <= sum[DOT_W-1:0];
      last_of_job <= s2_op.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      out_valid   <= 1'b0;
      accumulator <= '0;
    end else if (advance) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      out_valid <= mac && s2_op.row_done;
      if (s2_valid && s2_op.row_done) begin
        accumulator <= '0;
      end else if (mac) begin
        accumulator <= sum;
      end
    end
  end

endmodule

// ----- tb/sv/tb_matrix_multiply_transposed_b.sv -----
`timescale 1ns / 100ps

module tb_matrix_multiply_transposed_b;
  import mmtb_pkg::*;

  localparam int     CLK_PERIOD   = 8;
  localparam int     ROW_DEPTH    = 2048;
  localparam int     RESET_CYCLES = 12;
  // Results pass through a four-deep queue and the datapath registers: leave margin past both.
  localparam int     DRAIN_CYCLES = 12;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     RANDOM_WORDS = 870;
  // Watchdog limit on the whole run, well past the slowest correct run.
  localparam longint LIMIT_NS     = 64'd32_000_000;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [DOT_W-1:0]   dot;
    logic               last;
  } dot_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [1:0]           cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [ELEM_W-1:0]    element_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [INDEX_W-1:0]   out_index;
  logic [DOT_W-1:0]     dot_value;
  logic                 last_of_job;

  // Shadow copy of the block: registers as written, row store and counters.
  logic [ROWS_W-1:0]    rows_reg;
  logic [INNER_W-1:0]   inner_reg;
  logic [COLS_W-1:0]    cols_reg;
  logic [ELEM_W-1:0]    a_row_mem [ROW_DEPTH];
  int unsigned          elem_pos;
  int unsigned          b_row;
  int unsigned          a_row;
  bit                   loading_a;
  logic [ACC_W-1:0]     dot_acc;
  logic [INDEX_W-1:0]   next_index;

  dot_result_t          expected_dots[$];
  int unsigned          words_sent;
  int unsigned          mismatch_count;
  bit                   in_gaps_on;
  bit                   out_stalls_on;
  bit                   hold_off_req;

  matrix_multiply_transposed_b #(.ROW_DEPTH(ROW_DEPTH)) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_index     (out_index),
    .dot_value     (dot_value),
    .last_of_job   (last_of_job)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Zero counts as one; oversize values saturate.
  function automatic int unsigned used_size(input int unsigned raw, input int unsigned ceiling);
    if (raw == 0) return 1;
    return (raw > ceiling) ? ceiling : raw;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return ELEM_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Small sizes mostly, sometimes zero, sometimes a bit past the usual range.
  function automatic int unsigned pick_size(input int unsigned usual_max);
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(usual_max + 1, 2 * usual_max + 2);
    return $urandom_range(1, usual_max);
  endfunction

  // Advance the shadow block by one accepted word; queue the dot product
  // when the word closes a B row.
  task automatic step_dot_product(input logic [ELEM_W-1:0] word);
    int unsigned rows;
    int unsigned cols;
    int unsigned inner;
    int unsigned slot;
    bit          row_end;
    bit          last_col;
    bit          last_row;
    dot_result_t res;
    rows  = used_size(32'(rows_reg), MAX_ROWS);
    cols  = used_size(32'(cols_reg), MAX_COLS);
    inner = used_size(32'(inner_reg), MAX_INNER);
    if (inner > ROW_DEPTH) inner = ROW_DEPTH;
    slot    = elem_pos % ROW_DEPTH;
    // compare with >= so a bound lowered mid-row ends the row on this word
    row_end = (elem_pos + 1 >= inner);

    if (loading_a) begin
      a_row_mem[slot] = word;
      if (row_end) begin
        elem_pos  = 0;
        loading_a = 1'b0;
        dot_acc   = '0;
      end else begin
        elem_pos++;
      end
      return;
    end

    dot_acc = dot_acc + ACC_W'(a_row_mem[slot]) * ACC_W'(word);
    if (!row_end) begin
      elem_pos++;
      return;
    end

    last_col  = (b_row + 1 >= cols);
    last_row  = (a_row + 1 >= rows);
    res.index = next_index;
    res.dot   = dot_acc[DOT_W-1:0];
    res.last  = last_col && last_row;
    expected_dots.push_back(res);

    elem_pos   = 0;
    dot_acc    = '0;
    next_index = next_index + 1'b1;
    if (last_col) begin
      b_row     = 0;
      loading_a = 1'b1;
      if (last_row) begin
        a_row      = 0;
        next_index = '0;
      end else begin
        a_row++;
      end
    end else begin
      b_row++;
    end
  endtask

  // Offer one word after an optional gap; hold it until accepted.
  // Valid stays high on return so back-to-back words need no reassertion.
  task automatic send_word(input logic [ELEM_W-1:0] word);
    int unsigned gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    element_value <= word;
    do @(posedge clk); while (!in_ready);
    step_dot_product(word);
    words_sent++;
  endtask

  // Drop valid, wait for every queued result, then let the pipe empty.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_dots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t which, input int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data  <= CFG_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    case (which)
      REG_ROWS_A:    rows_reg  = ROWS_W'(value);
      REG_INNER_DIM: inner_reg = INNER_W'(value);
      REG_COLS_B:    cols_reg  = COLS_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_dims(input int unsigned rows, input int unsigned inner,
                          input int unsigned cols);
    drain_results();
    write_reg(REG_ROWS_A, rows);
    write_reg(REG_INNER_DIM, inner);
    write_reg(REG_COLS_B, cols);
  endtask

  // Send random words until the shadow block is back at the start of a job.
  task automatic finish_job();
    while (!(loading_a && elem_pos == 0 && a_row == 0 && b_row == 0))
      send_word(pick_element());
  endtask

  task automatic run_job();
    send_word(pick_element());
    finish_job();
  endtask

  task automatic test_basic_products();
    logic [ELEM_W-1:0] words [12] = '{
      16'h8000, 16'h0001,                       // A row 0
      16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,   // B rows 0 and 1
      16'h7FFF, 16'h0002,                       // A row 1
      16'h1234, 16'hFFFF, 16'hFFFF, 16'h0000    // B rows 0 and 1, last of job
    };
    // Sizes are all one after reset: each pair of words is a full job.
    send_word(16'hFFFF);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'h5A5A);
    set_dims(2, 2, 2);
    foreach (words[i]) send_word(words[i]);
  endtask

  task automatic test_zero_registers();
    // zero in every register must behave as one
    set_dims(0, 0, 0);
    send_word(16'hFFFF);
    send_word(16'h0001);
    send_word(16'h0100);
    send_word(16'h00FF);
  endtask

  task automatic test_midjob_rewrite();
    set_dims(3, 4, 2);
    // A row plus three words of the first B row
    repeat (7) send_word(pick_element());
    drain_results();
    // Position is already past the new bound: the row ends on the next word.
    write_reg(REG_INNER_DIM, 1);
    send_word(pick_element());
    drain_results();
    // Shrink both outer sizes to one: the next row ends the job.
    write_reg(REG_COLS_B, 1);
    write_reg(REG_ROWS_A, 1);
    send_word(pick_element());
    finish_job();
  endtask

  task automatic test_register_extremes();
    // oversize values in every register: load part of a long A row
    set_dims(2047, 4095, 2047);
    repeat (40) send_word(pick_element());
    drain_results();
    // the A row ends on the next word, then one-word B rows follow
    write_reg(REG_INNER_DIM, 1);
    repeat (6) send_word(pick_element());
    drain_results();
    // both outer sizes drop to one: the next B row ends the job
    write_reg(REG_COLS_B, 1);
    write_reg(REG_ROWS_A, 1);
    send_word(pick_element());
    // all-ones words: the dot product grows well past 32 bits
    set_dims(1, 64, 1);
    repeat (128) send_word('1);
  endtask

  task automatic test_output_backpressure();
    set_dims(1, 1, 1);
    in_gaps_on   = 1'b0;
    // receiver holds off on its own count while words keep coming
    hold_off_req = 1'b1;
    repeat (80) send_word(pick_element());
    drain_results();
    in_gaps_on   = 1'b1;
  endtask

  task automatic test_random_jobs();
    int unsigned first_word;
    int unsigned rows;
    int unsigned inner;
    int unsigned cols;
    first_word = words_sent;
    while (words_sent - first_word < RANDOM_WORDS) begin
      drain_results();
      in_gaps_on    = ($urandom_range(0, 4) != 0);
      out_stalls_on = ($urandom_range(0, 4) != 0);
      rows  = pick_size(3);
      inner = pick_size(10);
      cols  = pick_size(5);
      // Never grow the row while B words stream in: that would read
      // row entries that were not loaded for this A row.
      if (!loading_a && used_size(inner, MAX_INNER) > used_size(32'(inner_reg), MAX_INNER))
        inner = 32'(inner_reg);
      if ($urandom_range(0, 2) != 0) write_reg(REG_ROWS_A, rows);
      if ($urandom_range(0, 2) != 0) write_reg(REG_INNER_DIM, inner);
      if ($urandom_range(0, 2) != 0) write_reg(REG_COLS_B, cols);
      if ($urandom_range(0, 3) == 0) begin
        // stop part way through a job
        repeat ($urandom_range(1, 20)) send_word(pick_element());
      end else begin
        finish_job();
        repeat ($urandom_range(0, 2)) run_job();
      end
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // Receiver: random stalls, or one long hold-off on request.
  initial begin : result_receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (out_stalls_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each accepted result word with the oldest expected dot product.
  always @(posedge clk) begin : check_results
    dot_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_dots.size() == 0) begin
        $display("%0t: result with none expected: index %0d dot %0d last %0d",
                 $time, out_index, dot_value, last_of_job);
        mismatch_count++;
      end else begin
        want = expected_dots.pop_front();
        if (out_index !== want.index) begin
          $display("%0t: out_index expected %0d, got %0d", $time, want.index, out_index);
          mismatch_count++;
        end
        if (dot_value !== want.dot) begin
          $display("%0t: dot_value expected %0d, got %0d", $time, want.dot, dot_value);
          mismatch_count++;
        end
        if (last_of_job !== want.last) begin
          $display("%0t: last_of_job expected %0d, got %0d", $time, want.last, last_of_job);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = REG_ROWS_A;
    cfg_data       = '0;
    in_valid       = 1'b0;
    element_value  = '0;
    in_gaps_on     = 1'b1;
    out_stalls_on  = 1'b1;
    hold_off_req   = 1'b0;
    words_sent     = 0;
    mismatch_count = 0;
    // shadow state as reset leaves the block
    rows_reg       = ROWS_W'(1);
    inner_reg      = INNER_W'(1);
    cols_reg       = COLS_W'(1);
    elem_pos       = 0;
    loading_a      = 1'b1;
    b_row          = 0;
    a_row          = 0;
    dot_acc        = '0;
    next_index     = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_products();
    test_zero_registers();
    test_midjob_rewrite();
    test_register_extremes();
    test_output_backpressure();
    test_random_jobs();
    drain_results();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mmtb_pkg.sv
rtl/mmtb_front.sv
rtl/mmtb_queue.sv
rtl/mmtb_back.sv
rtl/matrix_multiply_transposed_b.sv
tb/sv/tb_matrix_multiply_transposed_b.sv
